/* hdl/u8dec_pkg.sv */
// Package for the streaming UTF-8 decoder.
// Holds field widths, the replacement code point and the result item type.
// No dependencies.
`default_nettype none

package u8dec_pkg;

   // Widths of the item fields and of the decoder state.
   localparam int BYTE_W = 8;
   localparam int CP_W   = 31;
   localparam int PEND_W = 3;

   // Code point emitted in place of a broken sequence.
   localparam logic [CP_W-1:0] REPL_CP = 31'h0000FFFD;

   // One result item as it sits in the output registers.
   typedef struct packed {
      logic [CP_W-1:0] code_point;
      logic            is_replacement;
      logic            last_of_run;
   } result_type;

endpackage : u8dec_pkg

`default_nettype wire

/* hdl/utf8_stream_decoder.sv */
// Streaming decoder for the original UTF-8 form (1 to 6 bytes, 31-bit code points).
// An accepted byte is held in the input register; its results then move to the result
// register and are shown on the result port, the first one first.
// Throughput: one byte per cycle while the result register has room for the byte's results;
// two results are shown one after the other. Reset (synchronous, active high) empties both
// registers and closes any open sequence. Depends on u8dec_pkg.
`default_nettype none

module utf8_stream_decoder (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [u8dec_pkg::BYTE_W-1:0]  req_byte_in,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [u8dec_pkg::CP_W-1:0]         rsp_code_point,
   output logic                               rsp_is_replacement,
   output logic                               rsp_last_of_run
);
   import u8dec_pkg::*;

   // Input register.
   logic              s1_valid_ff, s1_valid_in;
   logic [BYTE_W-1:0] s1_byte_ff, s1_byte_in;

   // Decoder state.
   logic [PEND_W-1:0] pend_ff, pend_in;
   logic [CP_W-1:0]   part_ff, part_in;

   // Result register: up to two items, the first one shown on the port.
   result_type        r0_ff, r0_in, r1_ff, r1_in;
   logic [1:0]        cnt_ff, cnt_in;

   // Decode results of the byte in the input register.
   logic              is_cont, is_ascii, is_bad, first_repl, s_has;
   logic [PEND_W-1:0] follow, pend_next;
   logic [CP_W-1:0]   payload, shifted, part_next;
   logic [1:0]        n_res;
   result_type        res0, res1, sres;

   logic              rsp_fire, pair_free, s1_adv;

   // Handshake and advance control.
   assign rsp_fire  = rsp_valid && rsp_ready;
   assign pair_free = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && rsp_fire);
   assign s1_adv    = s1_valid_ff && ((n_res == 2'd0) || pair_free);
   assign req_ready = !s1_valid_ff || s1_adv;

   assign rsp_valid          = (cnt_ff != 2'd0);
   assign rsp_code_point     = r0_ff.code_point;
   assign rsp_is_replacement = r0_ff.is_replacement;
   assign rsp_last_of_run    = r0_ff.last_of_run;

   // Lead byte classification: count of continuation bytes and payload bits.
   always_comb begin
      follow  = '0;
      payload = '0;
      if (s1_byte_ff[7:5] == 3'b110) begin
         follow  = PEND_W'(1);
         payload = CP_W'(s1_byte_ff[4:0]);
      end else if (s1_byte_ff[7:4] == 4'b1110) begin
         follow  = PEND_W'(2);
         payload = CP_W'(s1_byte_ff[3:0]);
      end else if (s1_byte_ff[7:3] == 5'b11110) begin
         follow  = PEND_W'(3);
         payload = CP_W'(s1_byte_ff[2:0]);
      end else if (s1_byte_ff[7:2] == 6'b111110) begin
         follow  = PEND_W'(4);
         payload = CP_W'(s1_byte_ff[1:0]);
      end else if (s1_byte_ff[7:1] == 7'b1111110) begin
         follow  = PEND_W'(5);
         payload = CP_W'(s1_byte_ff[0]);
      end
   end

   // One decode step: next state and the zero, one or two results of the item.
   always_comb begin
      is_cont    = (s1_byte_ff[7:6] == 2'b10);
      is_ascii   = !s1_byte_ff[7];
      is_bad     = (s1_byte_ff[7:1] == 7'b1111111);
      shifted    = {part_ff[CP_W-7:0], s1_byte_ff[5:0]};
      first_repl = 1'b0;
      s_has      = 1'b0;
      sres       = '0;
      res0       = '0;
      res1       = '0;
      n_res      = 2'd0;
      pend_next  = pend_ff;
      part_next  = part_ff;

      if ((pend_ff != '0) && is_cont) begin
         // Continuation byte of an open sequence.
         pend_next = pend_ff - PEND_W'(1);
         if (pend_ff == PEND_W'(1)) begin
            res0.code_point = shifted;
            n_res           = 2'd1;
            part_next       = '0;
         end else begin
            part_next = shifted;
         end
      end else begin
         // A byte that breaks an open sequence first gives a replacement item.
         if (pend_ff != '0) begin
            first_repl = 1'b1;
            pend_next  = '0;
            part_next  = '0;
         end
         // Fresh start: ASCII passes, invalid leads are replaced, strays are dropped.
         if (is_ascii) begin
            s_has           = 1'b1;
            sres.code_point = CP_W'(s1_byte_ff);
         end else if (is_bad) begin
            s_has               = 1'b1;
            sres.code_point     = REPL_CP;
            sres.is_replacement = 1'b1;
         end else if (!is_cont) begin
            pend_next = follow;
            part_next = payload;
         end
         if (first_repl) begin
            res0.code_point     = REPL_CP;
            res0.is_replacement = 1'b1;
            res1                = sres;
            n_res               = s_has ? 2'd2 : 2'd1;
         end else begin
            res0  = sres;
            n_res = s_has ? 2'd1 : 2'd0;
         end
      end

      // The final result of the item carries the end-of-run flag.
      res0.last_of_run = (n_res == 2'd1);
      res1.last_of_run = 1'b1;
   end

   // Next values of the input register, the state and the result register.
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_byte_in  = s1_byte_ff;
      pend_in     = pend_ff;
      part_in     = part_ff;
      r0_in       = r0_ff;
      r1_in       = r1_ff;
      cnt_in      = cnt_ff;

      if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      if (req_valid && req_ready) begin
         s1_valid_in = 1'b1;
         s1_byte_in  = req_byte_in;
      end

      // Drain the shown item; a second item moves up.
      if (rsp_fire) begin
         r0_in  = r1_ff;
         cnt_in = cnt_ff - 2'd1;
      end

      if (s1_adv) begin
         pend_in = pend_next;
         part_in = part_next;
         if (n_res != 2'd0) begin
            r0_in  = res0;
            r1_in  = res1;
            cnt_in = n_res;
         end
      end
   end

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         pend_ff     <= '0;
         part_ff     <= '0;
         cnt_ff      <= 2'd0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         pend_ff     <= pend_in;
         part_ff     <= part_in;
         cnt_ff      <= cnt_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      s1_byte_ff <= s1_byte_in;
      r0_ff      <= r0_in;
      r1_ff      <= r1_in;
   end

endmodule : utf8_stream_decoder

`default_nettype wire
